// ----- hdl/irmc_pkg.sv -----
// Shared types and constants for the IR remote motor command receiver.
// No dependencies; the RTL files refer to this package by scoped names and the bench imports it.
package irmc_pkg;

  localparam int unsigned GapW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SpeedW   = 4;
  localparam int unsigned FrameW   = 16;

  localparam logic [1:0]      ListenChannelRst = 2'd0;
  localparam logic [GapW-1:0] ZeroGapMinRst    = 12'd316;
  localparam logic [GapW-1:0] OneGapMinRst     = 12'd526;
  localparam logic [GapW-1:0] StartGapMinRst   = 12'd947;
  localparam logic [GapW-1:0] StartGapLimitRst = 12'd1579;

  localparam logic [3:0] ChecksumSeed = 4'hF;
  localparam logic [3:0] DataStepUp   = 4'h4;
  localparam logic [3:0] DataStepDown = 4'h5;
  localparam logic [3:0] DataBrake    = 4'h8;

  localparam logic signed [SpeedW-1:0] SpeedMax = 4'sd7;
  localparam logic signed [SpeedW-1:0] SpeedMin = -4'sd7;
  localparam logic [5:0] ServoOffset = 6'd22;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LISTEN_CHANNEL  = 3'd0,
    CFG_ZERO_GAP_MIN    = 3'd1,
    CFG_ONE_GAP_MIN     = 3'd2,
    CFG_START_GAP_MIN   = 3'd3,
    CFG_START_GAP_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_EDGE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_UP    = 2'd1,
    OP_DOWN  = 2'd2,
    OP_BRAKE = 2'd3
  } motor_op_e;

  typedef enum logic [1:0] {
    DIR_BRAKE   = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_e;

  // Decoded frame handed from the frame decoder to the motor control.
  typedef struct packed {
    logic      valid;
    motor_op_e op;
    logic      blue;
    logic [2:0] mode;
    logic [3:0] data;
  } frame_cmd_t;

  typedef struct packed {
    logic [1:0]              red_direction;
    logic [7:0]              red_duty;
    logic [1:0]              blue_direction;
    logic [7:0]              blue_duty;
    logic [5:0]              servo_compare;
    logic signed [SpeedW-1:0] red_level;
    logic signed [SpeedW-1:0] blue_level;
    logic [2:0]              frame_mode;
    logic [3:0]              frame_data;
  } result_t;

endpackage

// ----- hdl/irmc_frame_dec.sv -----
// Configuration registers, gap classification, frame shift register and
// toggle/checksum validation. Depends on irmc_pkg.
module irmc_frame_dec (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [irmc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [irmc_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               accept_i,
  input  logic                               command_i,
  input  logic [irmc_pkg::GapW-1:0]          gap_us_i,
  output irmc_pkg::frame_cmd_t               frame_o
);

  logic [1:0]                    listen_q;
  logic [irmc_pkg::GapW-1:0]     zero_min_q, one_min_q, start_min_q, start_lim_q;
  logic [irmc_pkg::FrameW-1:0]   shift_q, shift_d;
  logic                          toggle_q, toggle_d;

  logic       f_toggle;
  logic [3:0] f_check, f_calc, f_data;
  logic [1:0] f_chan;
  logic       f_addr;
  logic [2:0] f_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q    <= irmc_pkg::ListenChannelRst;
      zero_min_q  <= irmc_pkg::ZeroGapMinRst;
      one_min_q   <= irmc_pkg::OneGapMinRst;
      start_min_q <= irmc_pkg::StartGapMinRst;
      start_lim_q <= irmc_pkg::StartGapLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irmc_pkg::CFG_LISTEN_CHANNEL:  listen_q    <= cfg_wdata_i[1:0];
        irmc_pkg::CFG_ZERO_GAP_MIN:    zero_min_q  <= cfg_wdata_i;
        irmc_pkg::CFG_ONE_GAP_MIN:     one_min_q   <= cfg_wdata_i;
        irmc_pkg::CFG_START_GAP_MIN:   start_min_q <= cfg_wdata_i;
        irmc_pkg::CFG_START_GAP_LIMIT: start_lim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign f_toggle = shift_q[15];
  assign f_chan   = shift_q[13:12];
  assign f_addr   = shift_q[11];
  assign f_mode   = shift_q[10:8];
  assign f_data   = shift_q[7:4];
  assign f_check  = shift_q[3:0];
  assign f_calc   = irmc_pkg::ChecksumSeed ^ shift_q[15:12] ^ shift_q[11:8] ^ shift_q[7:4];

  always_comb begin
    shift_d       = shift_q;
    toggle_d      = toggle_q;
    frame_o       = '0;
    frame_o.op    = irmc_pkg::OP_NONE;
    frame_o.blue  = f_mode[0];
    frame_o.mode  = f_mode;
    frame_o.data  = f_data;
    if (accept_i) begin
      if (command_i == irmc_pkg::CMD_EDGE) begin
        // Classes are tested in order; the first match wins.
        if (gap_us_i >= zero_min_q && gap_us_i < one_min_q) begin
          shift_d = {shift_q[irmc_pkg::FrameW-2:0], 1'b0};
        end else if (gap_us_i >= one_min_q && gap_us_i < start_min_q) begin
          shift_d = {shift_q[irmc_pkg::FrameW-2:0], 1'b1};
        end else if (gap_us_i >= start_min_q && gap_us_i < start_lim_q) begin
          shift_d = '0;
        end
      end else begin
        shift_d = '0;
        if (f_toggle != toggle_q && f_check == f_calc) begin
          toggle_d      = f_toggle;
          frame_o.valid = 1'b1;
          if (f_chan == listen_q && !f_addr && f_mode[2]) begin
            if (f_mode[1]) begin
              if (f_data == irmc_pkg::DataStepUp) begin
                frame_o.op = irmc_pkg::OP_UP;
              end else if (f_data == irmc_pkg::DataStepDown) begin
                frame_o.op = irmc_pkg::OP_DOWN;
              end
            end else if (f_data == irmc_pkg::DataBrake) begin
              frame_o.op = irmc_pkg::OP_BRAKE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      toggle_q <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      toggle_q <= toggle_d;
    end
  end

endmodule

// ----- hdl/irmc_motor_ctl.sv -----
// Motor speed registers and result formatting (direction, duty, servo).
// Depends on irmc_pkg.
module irmc_motor_ctl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  irmc_pkg::frame_cmd_t frame_i,
  output logic                 push_o,
  output irmc_pkg::result_t    result_o
);

  logic signed [irmc_pkg::SpeedW-1:0] red_q, red_d, blue_q, blue_d;
  logic signed [irmc_pkg::SpeedW-1:0] sel_s, new_s;

  function automatic logic [1:0] dir_of(input logic signed [3:0] s);
    if (s > 4'sd0) begin
      return irmc_pkg::DIR_FORWARD;
    end else if (s < 4'sd0) begin
      return irmc_pkg::DIR_REVERSE;
    end
    return irmc_pkg::DIR_BRAKE;
  endfunction

  function automatic logic [7:0] duty_of(input logic signed [3:0] s);
    logic [3:0] mag;
    mag = s[3] ? 4'(-s) : 4'(s);
    return {mag[2:0], 5'b0};
  endfunction

  assign sel_s = frame_i.blue ? blue_q : red_q;

  always_comb begin
    case (frame_i.op)
      irmc_pkg::OP_UP:    new_s = (sel_s >= irmc_pkg::SpeedMax) ? irmc_pkg::SpeedMax
                                                                 : sel_s + 4'sd1;
      irmc_pkg::OP_DOWN:  new_s = (sel_s <= irmc_pkg::SpeedMin) ? irmc_pkg::SpeedMin
                                                                 : sel_s - 4'sd1;
      irmc_pkg::OP_BRAKE: new_s = '0;
      default:            new_s = sel_s;
    endcase
    red_d  = red_q;
    blue_d = blue_q;
    if (frame_i.valid) begin
      if (frame_i.blue) begin
        blue_d = new_s;
      end else begin
        red_d = new_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q  <= '0;
      blue_q <= '0;
    end else begin
      red_q  <= red_d;
      blue_q <= blue_d;
    end
  end

  assign push_o = frame_i.valid;

  always_comb begin
    result_o.red_direction  = dir_of(red_d);
    result_o.red_duty       = duty_of(red_d);
    result_o.blue_direction = dir_of(blue_d);
    result_o.blue_duty      = duty_of(blue_d);
    result_o.servo_compare  = {{2{blue_d[3]}}, blue_d[2:0], 1'b0} + irmc_pkg::ServoOffset;
    result_o.red_level      = red_d;
    result_o.blue_level     = blue_d;
    result_o.frame_mode     = frame_i.mode;
    result_o.frame_data     = frame_i.data;
  end

endmodule

// ----- hdl/irmc_out_fifo.sv -----
// Two-entry result queue: two stored entries with read and write pointers, so edge events
// keep flowing while a result waits. Depends on irmc_pkg.
module irmc_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  irmc_pkg::result_t wdata_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output irmc_pkg::result_t rdata_o
);

  irmc_pkg::result_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign space_o = cnt_q != 2'd2;
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/ir_remote_motor_command_receiver_top.sv -----
// Top level of the IR remote motor command receiver.
// Depends on irmc_pkg, irmc_frame_dec, irmc_motor_ctl and irmc_out_fifo.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid_i / in_ready_o | command_i, gap_us_i
//   out     | out_valid_o/out_ready_i | directions, duties, servo, levels, frame
//   cfg     | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One request is taken per cycle while the queue has space; a frame timeout
// that passes the checks has its result registered into the queue, behind any result still waiting.
// Two result entries are queued, so input stalls only when both are held.
// Reset clears the frame, the toggle memory and both motor speeds, and
// loads the default gap thresholds and channel 0.
module ir_remote_motor_command_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irmc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [irmc_pkg::GapW-1:0]     gap_us_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    red_direction_o,
  output logic [7:0]                    red_duty_o,
  output logic [1:0]                    blue_direction_o,
  output logic [7:0]                    blue_duty_o,
  output logic [5:0]                    servo_compare_o,
  output logic signed [3:0]             red_level_o,
  output logic signed [3:0]             blue_level_o,
  output logic [2:0]                    frame_mode_o,
  output logic [3:0]                    frame_data_o
);

  logic                 accept;
  logic                 push;
  irmc_pkg::frame_cmd_t frame;
  irmc_pkg::result_t    result, out_res;

  assign accept = in_valid_i && in_ready_o;

  irmc_frame_dec u_frame_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .command_i   (command_i),
    .gap_us_i    (gap_us_i),
    .frame_o     (frame)
  );

  irmc_motor_ctl u_motor_ctl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame),
    .push_o   (push),
    .result_o (result)
  );

  irmc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (result),
    .space_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rdata_o (out_res)
  );

  assign red_direction_o  = out_res.red_direction;
  assign red_duty_o       = out_res.red_duty;
  assign blue_direction_o = out_res.blue_direction;
  assign blue_duty_o      = out_res.blue_duty;
  assign servo_compare_o  = out_res.servo_compare;
  assign red_level_o      = out_res.red_level;
  assign blue_level_o     = out_res.blue_level;
  assign frame_mode_o     = out_res.frame_mode;
  assign frame_data_o     = out_res.frame_data;

  // A full queue always has a result on offer.
  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Saturation keeps both speeds inside plus and minus seven.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_level_o != -4'sd8) && (blue_level_o != -4'sd8))
    else $error("motor level out of range");

  // Direction and duty must agree on a stopped motor.
  a_brake_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((red_direction_o == irmc_pkg::DIR_BRAKE) == (red_duty_o == 8'd0))
                 && ((blue_direction_o == irmc_pkg::DIR_BRAKE) == (blue_duty_o == 8'd0)))
    else $error("direction and duty disagree");

  // An edge event never produces a result.
  a_edge_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == irmc_pkg::CMD_EDGE |-> !push)
    else $error("edge event produced a result");

endmodule

// ----- bench/ir_remote_motor_command_receiver_top_tb.sv -----
// Self-checking bench for ir_remote_motor_command_receiver_top: a queued request driver,
// a result monitor and a request-level predictor of frame decoding and motor control.
// Depends on irmc_pkg and the receiver RTL only.
module ir_remote_motor_command_receiver_top_tb;

  import irmc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;

  typedef enum logic [1:0] {
    GAP_NONE  = 2'd0,
    GAP_ZERO  = 2'd1,
    GAP_ONE   = 2'd2,
    GAP_START = 2'd3
  } gap_kind_e;

  typedef struct {
    cmd_e            cmd;
    logic [GapW-1:0] gap;
  } ir_event_t;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_command = 1'b0;
  logic [GapW-1:0]     in_gap = '0;
  logic                out_ready = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [1:0]          red_direction;
  logic [7:0]          red_duty;
  logic [1:0]          blue_direction;
  logic [7:0]          blue_duty;
  logic [5:0]          servo_compare;
  logic signed [3:0]   red_level;
  logic signed [3:0]   blue_level;
  logic [2:0]          frame_mode;
  logic [3:0]          frame_data;

  ir_remote_motor_command_receiver_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (in_command),
    .gap_us_i         (in_gap),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .red_direction_o  (red_direction),
    .red_duty_o       (red_duty),
    .blue_direction_o (blue_direction),
    .blue_duty_o      (blue_duty),
    .servo_compare_o  (servo_compare),
    .red_level_o      (red_level),
    .blue_level_o     (blue_level),
    .frame_mode_o     (frame_mode),
    .frame_data_o     (frame_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the threshold and channel registers.
  logic [1:0]      listen_ch   = ListenChannelRst;
  logic [GapW-1:0] zero_min    = ZeroGapMinRst;
  logic [GapW-1:0] one_min     = OneGapMinRst;
  logic [GapW-1:0] start_min   = StartGapMinRst;
  logic [GapW-1:0] start_limit = StartGapLimitRst;

  // Predicted receiver state.
  logic [FrameW-1:0]        ir_frame = '0;
  logic                     last_tog = 1'b0;
  logic signed [SpeedW-1:0] red_spd  = '0;
  logic signed [SpeedW-1:0] blue_spd = '0;

  ir_event_t ir_event_q[$];
  result_t   motor_status_q[$];

  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned phase_count    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_wait      = 0;
  int unsigned send_burst     = 0;
  int unsigned recv_wait      = 0;
  int unsigned recv_burst     = 0;
  int unsigned queued_items   = 0;
  logic        gen_tog        = 1'b0;
  ir_event_t   next_ev;

  function automatic gap_kind_e gap_class(logic [GapW-1:0] gap);
    if (gap >= zero_min && gap < one_min) return GAP_ZERO;
    if (gap >= one_min && gap < start_min) return GAP_ONE;
    if (gap >= start_min && gap < start_limit) return GAP_START;
    return GAP_NONE;
  endfunction

  function automatic logic [1:0] dir_of(logic signed [SpeedW-1:0] s);
    if (s > 4'sd0) return DIR_FORWARD;
    if (s < 4'sd0) return DIR_REVERSE;
    return DIR_BRAKE;
  endfunction

  function automatic logic [7:0] duty_of(logic signed [SpeedW-1:0] s);
    logic signed [SpeedW-1:0] mag;
    mag = (s < 4'sd0) ? -s : s;
    return {mag[2:0], 5'd0};
  endfunction

  // Applies one accepted request to the predicted state and queues the status
  // that an accepted frame reports.
  task automatic decode_ir_event(cmd_e cmd, logic [GapW-1:0] gap);
    logic [FrameW-1:0] f;
    logic [3:0]        sum;
    logic [2:0]        mode;
    logic [3:0]        data;
    result_t           res;
    if (cmd == CMD_EDGE) begin
      case (gap_class(gap))
        GAP_ZERO:  ir_frame = {ir_frame[FrameW-2:0], 1'b0};
        GAP_ONE:   ir_frame = {ir_frame[FrameW-2:0], 1'b1};
        GAP_START: ir_frame = '0;
        default:   ;
      endcase
    end else begin
      f = ir_frame;
      ir_frame = '0;
      sum = ChecksumSeed ^ f[15:12] ^ f[11:8] ^ f[7:4];
      mode = f[10:8];
      data = f[7:4];
      if (f[15] != last_tog && f[3:0] == sum) begin
        last_tog = f[15];
        if (f[13:12] == listen_ch && !f[11] && mode[2]) begin
          if (mode[1]) begin
            if (data == DataStepUp) begin
              if (mode[0]) begin
                if (blue_spd < SpeedMax) blue_spd = blue_spd + 4'sd1;
              end else if (red_spd < SpeedMax) begin
                red_spd = red_spd + 4'sd1;
              end
            end else if (data == DataStepDown) begin
              if (mode[0]) begin
                if (blue_spd > SpeedMin) blue_spd = blue_spd - 4'sd1;
              end else if (red_spd > SpeedMin) begin
                red_spd = red_spd - 4'sd1;
              end
            end
          end else if (data == DataBrake) begin
            if (mode[0]) blue_spd = '0;
            else red_spd = '0;
          end
        end
        res.red_direction  = dir_of(red_spd);
        res.red_duty       = duty_of(red_spd);
        res.blue_direction = dir_of(blue_spd);
        res.blue_duty      = duty_of(blue_spd);
        res.servo_compare  = 6'(int'(blue_spd) * 2 + int'(ServoOffset));
        res.red_level      = red_spd;
        res.blue_level     = blue_spd;
        res.frame_mode     = mode;
        res.frame_data     = data;
        motor_status_q.push_back(res);
      end
    end
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(80, 30);
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_ir_event(cmd_e'(in_command), in_gap);
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          in_valid  <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (ir_event_q.size() != 0) begin
          next_ev = ir_event_q.pop_front();
          in_command <= next_ev.cmd;
          in_gap     <= next_ev.gap;
          in_valid   <= 1'b1;
          if (send_burst != 0) begin
            send_burst <= send_burst - 1;
            send_wait  <= 0;
          end else if ($urandom_range(99) < 3) begin
            send_burst <= $urandom_range(120, 20);
            send_wait  <= 0;
          end else begin
            send_wait <= idle_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result();
    result_t seen;
    result_t want;
    seen.red_direction  = red_direction;
    seen.red_duty       = red_duty;
    seen.blue_direction = blue_direction;
    seen.blue_duty      = blue_duty;
    seen.servo_compare  = servo_compare;
    seen.red_level      = red_level;
    seen.blue_level     = blue_level;
    seen.frame_mode     = frame_mode;
    seen.frame_data     = frame_data;
    if (motor_status_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("unexpected status: mode %0d data %0d red %0d blue %0d",
                 seen.frame_mode, seen.frame_data, seen.red_level, seen.blue_level);
    end else begin
      want = motor_status_q.pop_front();
      checked_count++;
      if (seen !== want) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("status mismatch #%0d", mismatch_count);
          $display("  expected dir %0d/%0d duty %0d/%0d servo %0d lvl %0d/%0d mode %0d data %0d",
                   want.red_direction, want.blue_direction, want.red_duty, want.blue_duty,
                   want.servo_compare, want.red_level, want.blue_level,
                   want.frame_mode, want.frame_data);
          $display("  actual   dir %0d/%0d duty %0d/%0d servo %0d lvl %0d/%0d mode %0d data %0d",
                   seen.red_direction, seen.blue_direction, seen.red_duty, seen.blue_duty,
                   seen.servo_compare, seen.red_level, seen.blue_level,
                   seen.frame_mode, seen.frame_data);
        end
      end
    end
  endtask

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (recv_wait != 0) begin
        out_ready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else if (recv_burst != 0) begin
        out_ready  <= 1'b1;
        recv_burst <= recv_burst - 1;
      end else if ($urandom_range(99) < 2) begin
        out_ready  <= 1'b1;
        recv_burst <= $urandom_range(200, 50);
      end else if ($urandom_range(99) < 15) begin
        out_ready <= 1'b0;
        recv_wait <= idle_len();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_LISTEN_CHANNEL:  listen_ch   = value[1:0];
      CFG_ZERO_GAP_MIN:    zero_min    = value;
      CFG_ONE_GAP_MIN:     one_min     = value;
      CFG_START_GAP_MIN:   start_min   = value;
      CFG_START_GAP_LIMIT: start_limit = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle(int unsigned settle);
    @(posedge clk_i);
    while (ir_event_q.size() != 0 || in_valid || motor_status_q.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic push_event(cmd_e cmd, logic [GapW-1:0] gap);
    ir_event_t ev;
    ev.cmd = cmd;
    ev.gap = gap;
    ir_event_q.push_back(ev);
    queued_items++;
  endtask

  // Picks a gap that the current thresholds put in the wanted class, often
  // right on a threshold; falls back to any gap when the class is empty.
  function automatic logic [GapW-1:0] gap_of_kind(gap_kind_e want);
    logic [GapW-1:0] lo;
    logic [GapW-1:0] hi;
    logic [GapW-1:0] g;
    int              tries;
    case (want)
      GAP_ZERO: begin lo = zero_min;  hi = one_min;     end
      GAP_ONE:  begin lo = one_min;   hi = start_min;   end
      default:  begin lo = start_min; hi = start_limit; end
    endcase
    for (tries = 0; tries < 8; tries++) begin
      if (hi > lo) begin
        case ($urandom_range(9))
          0:       g = lo;
          1:       g = hi - 1;
          default: g = 12'($urandom_range(int'(hi) - 1, int'(lo)));
        endcase
        if (gap_class(g) == want) return g;
      end
    end
    return 12'($urandom_range(4095));
  endfunction

  function automatic logic [FrameW-1:0] make_word(logic tog, logic [1:0] chan, logic addr,
                                                  logic [2:0] mode, logic [3:0] data,
                                                  logic good);
    logic       esc;
    logic [3:0] sum;
    esc = 1'($urandom_range(1));
    sum = ChecksumSeed ^ {tog, esc, chan} ^ {addr, mode} ^ data;
    if (!good) sum = sum ^ 4'($urandom_range(15, 1));
    return {tog, esc, chan, addr, mode, data, sum};
  endfunction

  // Start bit, optional surplus bits that get shifted out, then the first
  // nbits of the word and a timeout.
  task automatic push_frame(logic [FrameW-1:0] word, int nbits, int extra);
    int i;
    push_event(CMD_EDGE, gap_of_kind(GAP_START));
    repeat (extra) push_event(CMD_EDGE, gap_of_kind($urandom_range(1) ? GAP_ONE : GAP_ZERO));
    for (i = 0; i < nbits; i++)
      push_event(CMD_EDGE, gap_of_kind(word[FrameW-1-i] ? GAP_ONE : GAP_ZERO));
    push_event(CMD_TIMEOUT, 12'($urandom_range(4095)));
  endtask

  function automatic logic [3:0] pick_data();
    if ($urandom_range(99) >= 70) return 4'($urandom_range(15));
    case ($urandom_range(2))
      0:       return DataStepUp;
      1:       return DataStepDown;
      default: return DataBrake;
    endcase
  endfunction

  task automatic push_good_frame(int extra);
    logic [1:0] chan;
    logic       addr;
    logic [2:0] mode;
    chan = ($urandom_range(99) < 80) ? listen_ch : 2'($urandom_range(3));
    addr = ($urandom_range(99) < 90) ? 1'b0 : 1'b1;
    mode = ($urandom_range(99) < 80) ? {1'b1, 2'($urandom_range(3))} : 3'($urandom_range(7));
    gen_tog = ~gen_tog;
    push_frame(make_word(gen_tog, chan, addr, mode, pick_data(), 1'b1), FrameW, extra);
  endtask

  task automatic fill_phase(int unsigned n_items);
    int unsigned target;
    int unsigned r;
    int          k;
    logic        blue;
    logic [3:0]  op;
    target = queued_items + n_items;
    while (queued_items < target) begin
      r = $urandom_range(99);
      if (r < 68) begin
        push_good_frame(0);
      end else if (r < 74) begin
        // A run of identical commands drives one motor toward saturation.
        blue = 1'($urandom_range(1));
        op = $urandom_range(1) ? DataStepUp : DataStepDown;
        for (k = 0; k < 9; k++) begin
          gen_tog = ~gen_tog;
          push_frame(make_word(gen_tog, listen_ch, 1'b0, {2'b11, blue}, op, 1'b1), FrameW, 0);
        end
        if ($urandom_range(1)) begin
          gen_tog = ~gen_tog;
          push_frame(make_word(gen_tog, listen_ch, 1'b0, {2'b10, blue}, DataBrake, 1'b1),
                     FrameW, 0);
        end
      end else if (r < 79) begin
        push_frame(make_word(1'($urandom_range(1)), 2'($urandom_range(3)), 1'b0,
                             3'($urandom_range(7)), pick_data(), 1'b0), FrameW, 0);
      end else if (r < 83) begin
        push_frame(make_word(gen_tog, listen_ch, 1'b0, 3'($urandom_range(7)),
                             pick_data(), 1'b1), FrameW, 0);
      end else if (r < 87) begin
        push_frame(16'($urandom_range(16'hFFFF)), $urandom_range(15), 0);
      end else if (r < 91) begin
        push_good_frame($urandom_range(6, 1));
      end else if (r < 95) begin
        // A frame cut short by a new start bit.
        push_event(CMD_EDGE, gap_of_kind(GAP_START));
        repeat ($urandom_range(10, 1))
          push_event(CMD_EDGE, gap_of_kind($urandom_range(1) ? GAP_ONE : GAP_ZERO));
        push_good_frame(0);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(3) == 0) push_event(CMD_TIMEOUT, 12'($urandom_range(4095)));
          else push_event(CMD_EDGE, 12'($urandom_range(4095)));
        end
      end
    end
  endtask

  // The sender waits here for every outstanding status before the
  // registers change, so each phase boundary doubles as a full drain.
  task automatic run_phase(logic [1:0] chan, logic [GapW-1:0] z, logic [GapW-1:0] o,
                           logic [GapW-1:0] s, logic [GapW-1:0] l, int unsigned n_items);
    wait_idle(4);
    write_reg(CFG_LISTEN_CHANNEL, {10'd0, chan});
    write_reg(CFG_ZERO_GAP_MIN, z);
    write_reg(CFG_ONE_GAP_MIN, o);
    write_reg(CFG_START_GAP_MIN, s);
    write_reg(CFG_START_GAP_LIMIT, l);
    phase_count++;
    fill_phase(n_items);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme gaps, a timeout on an empty frame, one red step up.
    push_event(CMD_EDGE, 12'd0);
    push_event(CMD_EDGE, 12'd4095);
    push_event(CMD_TIMEOUT, 12'd4095);
    gen_tog = 1'b1;
    push_frame(make_word(1'b1, 2'd0, 1'b0, 3'b110, DataStepUp, 1'b1), FrameW, 0);

    run_phase(2'd0, ZeroGapMinRst, OneGapMinRst, StartGapMinRst, StartGapLimitRst, 400);
    run_phase(2'd3, ZeroGapMinRst, OneGapMinRst, StartGapMinRst, StartGapLimitRst, 300);
    run_phase(2'd1, 12'd100, 12'd200, 12'd300, 12'd400, 300);
    run_phase(2'd2, 12'd0, 12'd2048, 12'd4000, 12'd4095, 300);
    // Overlapping thresholds leave the zero class empty.
    run_phase(2'd0, 12'd500, 12'd400, 12'd450, 12'd4095, 200);
    run_phase(2'd3, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 60);
    run_phase(2'd1, 12'd0, 12'd0, 12'd0, 12'd0, 40);
    run_phase(2'd0, ZeroGapMinRst, OneGapMinRst, StartGapMinRst, StartGapLimitRst, 200);

    wait_idle(8);
    $display("%0d IR requests over %0d register settings; %0d motor status results checked.",
             sent_count, phase_count, checked_count);
    $display("%0d mismatches seen.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/irmc_pkg.sv
hdl/irmc_frame_dec.sv
hdl/irmc_motor_ctl.sv
hdl/irmc_out_fifo.sv
hdl/ir_remote_motor_command_receiver_top.sv
bench/ir_remote_motor_command_receiver_top_tb.sv
